/* src/kgaq_pkg.sv */
// shared types, codes and fixed point helpers of the keypoint grid query block
`timescale 1ns / 1ps
package kgaq_pkg;

  // cell coordinates fit the largest grid side
  localparam int CRD_W = 8;

  // request codes on the input tuser
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_X = 2'd0;
  localparam logic [1:0] CFG_MIN_Y = 2'd1;
  localparam logic [1:0] CFG_INV_W = 2'd2;
  localparam logic [1:0] CFG_INV_H = 2'd3;

  // reset value of the inverse cell sizes
  localparam logic [19:0] INV_RESET = 20'd6554;

  // rounding modes of a q20 product
  typedef enum logic [1:0] {
    RND_NEAR  = 2'd0,
    RND_FLOOR = 2'd1,
    RND_CEIL  = 2'd2
  } rnd_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic [2:0]        level;
    logic [15:0]       radius;
    logic signed [3:0] minl;
    logic signed [3:0] maxl;
    logic              hit;
    logic [CRD_W-1:0]  x0;
    logic [CRD_W-1:0]  x1;
    logic [CRD_W-1:0]  y0;
    logic [CRD_W-1:0]  y1;
  } task_t;

  // one reply item
  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] index;
    logic        found;
    logic        ovf;
    logic        last;
  } reply_t;

  // q20 product to integer cell coordinate
  function automatic logic signed [20:0] q20_conv(input logic signed [39:0] p, input rnd_e m);
    logic signed [40:0] pe;
    logic signed [40:0] t;
    pe = 41'(p);
    case (m)
      RND_FLOOR: t = pe;
      RND_CEIL:  t = pe + 41'sd1048575;
      RND_NEAR: begin
        if (p[39]) t = pe + 41'sd524287;
        else       t = pe + 41'sd524288;
      end
      default:   t = pe;
    endcase
    return t[40:20];
  endfunction

endpackage

/* src/kgaq_front.sv */
// front end: takes requests, maps positions to cells and classifies them
`timescale 1ns / 1ps
module kgaq_front import kgaq_pkg::*; #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic [2:0]         level_i,
  input  logic [15:0]        radius_i,
  input  logic signed [3:0]  min_level_i,
  input  logic signed [3:0]  max_level_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               en_i,
  input  logic               full_i,
  output logic               push_o,
  output task_t              task_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic signed [20:0] COLS_S = 21'(GRID_COLS);
  localparam logic signed [20:0] ROWS_S = 21'(GRID_ROWS);

  logic [1:0]         state_q, state_d;
  logic [2:0]         step_q;
  logic signed [16:0] min_x_q, min_y_q;
  logic [19:0]        inv_w_q, inv_h_q;
  logic [1:0]         kind_q;
  logic signed [16:0] px_q, py_q;
  logic [2:0]         lvl_q;
  logic [15:0]        rad_q;
  logic signed [3:0]  minl_q, maxl_q;
  logic signed [39:0] prod_q;
  logic signed [20:0] res_q [4];

  logic signed [17:0] dx, dy;
  logic signed [18:0] op;
  logic [19:0]        inv;
  logic signed [39:0] prod;
  logic [1:0]         ridx;
  rnd_e               rmode;
  logic signed [20:0] x0c, x1c, y0c, y1c;
  logic               ins_hit, qry_hit, hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      inv_w_q <= INV_RESET;
      inv_h_q <= INV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_X: min_x_q <= $signed(cfg_data_i[16:0]);
        CFG_MIN_Y: min_y_q <= $signed(cfg_data_i[16:0]);
        CFG_INV_W: inv_w_q <= cfg_data_i;
        CFG_INV_H: inv_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset from grid origin and operand of the current step
  always_comb begin
    dx = 18'(px_q) - 18'(min_x_q);
    dy = 18'(py_q) - 18'(min_y_q);
    case (step_q[1:0])
      2'd0: op = (kind_q == REQ_INSERT) ? 19'(dx) : 19'(dx) - 19'($signed({1'b0, rad_q}));
      2'd1: op = 19'(dx) + 19'($signed({1'b0, rad_q}));
      2'd2: op = (kind_q == REQ_INSERT) ? 19'(dy) : 19'(dy) - 19'($signed({1'b0, rad_q}));
      default: op = 19'(dy) + 19'($signed({1'b0, rad_q}));
    endcase
    inv  = step_q[1] ? inv_h_q : inv_w_q;
    prod = 40'(op) * 40'($signed({1'b0, inv}));
    ridx = 2'(step_q - 3'd1);
    if (kind_q == REQ_INSERT) rmode = RND_NEAR;
    else if (ridx[0])         rmode = RND_CEIL;
    else                      rmode = RND_FLOOR;
  end

  // clamp the window and test the insert cell
  always_comb begin
    x0c = res_q[0][20] ? '0 : res_q[0];
    x1c = (res_q[1] > COLS_S - 21'sd1) ? COLS_S - 21'sd1 : res_q[1];
    y0c = res_q[2][20] ? '0 : res_q[2];
    y1c = (res_q[3] > ROWS_S - 21'sd1) ? ROWS_S - 21'sd1 : res_q[3];
    ins_hit = !res_q[0][20] && (res_q[0] < COLS_S) && !res_q[2][20] && (res_q[2] < ROWS_S);
    qry_hit = (x0c <= x1c) && (y0c <= y1c);
    hit = (kind_q == REQ_INSERT) ? ins_hit : qry_hit;
    task_o.kind   = kind_q;
    task_o.px     = px_q;
    task_o.py     = py_q;
    task_o.level  = lvl_q;
    task_o.radius = rad_q;
    task_o.minl   = minl_q;
    task_o.maxl   = maxl_q;
    task_o.hit    = hit;
    if (kind_q == REQ_INSERT) begin
      task_o.x0 = hit ? res_q[0][CRD_W-1:0] : '0;
      task_o.y0 = hit ? res_q[2][CRD_W-1:0] : '0;
    end else begin
      task_o.x0 = hit ? x0c[CRD_W-1:0] : '0;
      task_o.y0 = hit ? y0c[CRD_W-1:0] : '0;
    end
    task_o.x1 = hit ? x1c[CRD_W-1:0] : '0;
    task_o.y1 = hit ? y1c[CRD_W-1:0] : '0;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: if (in_valid_i && en_i) state_d = F_CALC;
      F_CALC: if (step_q == 3'd4) state_d = F_PUSH;
      F_PUSH: begin
        if (kind_q == 2'd3) begin
          state_d = F_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == F_IDLE) && en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_CALC) step_q <= step_q + 3'd1;
      else                   step_q <= '0;
    end
  end

  // request latch and shared multiplier
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= in_kind_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      lvl_q  <= level_i;
      rad_q  <= radius_i;
      minl_q <= min_level_i;
      maxl_q <= max_level_i;
    end
    if (state_q == F_CALC) begin
      if (step_q != 3'd4) prod_q <= prod;
      if (step_q != 3'd0) res_q[ridx] <= q20_conv(prod_q, rmode);
    end
  end

endmodule

/* src/kgaq_fifo.sv */
// two entry queue between front and back
`timescale 1ns / 1ps
module kgaq_fifo import kgaq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output task_t data_o
);

  task_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

/* src/kgaq_back.sv */
// back end: cell stores, point stores, insert and area walk, reply register
`timescale 1ns / 1ps
module kgaq_back import kgaq_pkg::*; #(
  parameter int GRID_COLS     = 64,
  parameter int GRID_ROWS     = 48,
  parameter int MAX_POINTS    = 2048,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_RESULTS   = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   task_valid_i,
  input  task_t  task_i,
  output logic   pop_o,
  output logic   ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output reply_t out_o
);

  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int NSLOTS = NCELLS * CELL_CAPACITY;
  localparam int CA_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int MA_W   = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int IW     = $clog2(MAX_POINTS);
  localparam int NPW    = $clog2(MAX_POINTS + 1);
  localparam int FW     = $clog2(CELL_CAPACITY + 1);
  localparam int JW     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
  localparam int RW     = $clog2(MAX_RESULTS + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_CREPLY = 4'd3;
  localparam logic [3:0] S_INS_RD = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_QCELL  = 4'd6;
  localparam logic [3:0] S_QFILL  = 4'd7;
  localparam logic [3:0] S_QMRD   = 4'd8;
  localparam logic [3:0] S_QMEM   = 4'd9;
  localparam logic [3:0] S_QTEST  = 4'd10;
  localparam logic [3:0] S_QEND   = 4'd11;

  // stores
  logic [FW-1:0]      fill_mem [NCELLS];
  logic [IW-1:0]      memb_mem [NSLOTS];
  logic signed [16:0] ptx_mem  [MAX_POINTS];
  logic signed [16:0] pty_mem  [MAX_POINTS];
  logic [2:0]         ptl_mem  [MAX_POINTS];

  logic [3:0]         state_q, state_d;
  task_t              tsk_q;
  logic [CRD_W-1:0]   ix_q, ix_d, iy_q, iy_d;
  logic [JW-1:0]      j_q, j_d;
  logic [CA_W-1:0]    clr_q;
  logic [NPW-1:0]     np_q, np_d;
  logic [RW-1:0]      n_q, n_d;
  logic               pend_v_q, pend_v_d;
  logic [IW-1:0]      pend_q, pend_d;
  logic [FW-1:0]      fill_rd_q;
  logic [IW-1:0]      memb_rd_q;
  logic signed [16:0] ptx_rd_q, pty_rd_q;
  logic [2:0]         ptl_rd_q;
  logic               out_v_q;
  reply_t             out_q, out_d;

  logic               fill_we, fill_re, memb_we, memb_re, pt_we, pt_re, out_load;
  logic [CA_W-1:0]    cell_addr, fill_waddr;
  logic [FW-1:0]      fill_wdata;
  logic [MA_W-1:0]    memb_waddr, memb_raddr;
  logic               out_free, last_cell, lvl_ok, box_ok, match, chk;
  logic signed [17:0] ddx, ddy;
  logic [17:0]        adx, ady;

  assign cell_addr  = CA_W'(CA_W'(ix_q) * CA_W'(GRID_ROWS) + CA_W'(iy_q));
  assign memb_waddr = MA_W'(MA_W'(cell_addr) * MA_W'(CELL_CAPACITY) + MA_W'(fill_rd_q));
  assign memb_raddr = MA_W'(MA_W'(cell_addr) * MA_W'(CELL_CAPACITY) + MA_W'(j_q));
  assign out_free   = !out_v_q || out_ready_i;
  assign last_cell  = (ix_q == tsk_q.x1) && (iy_q == tsk_q.y1);
  assign ready_o    = (state_q != S_INIT);
  assign out_valid_o = out_v_q;
  assign out_o      = out_q;

  // level filter and strict box test of the fetched point
  always_comb begin
    chk    = (tsk_q.minl > 4'sd0) || !tsk_q.maxl[3];
    lvl_ok = !chk || (($signed({1'b0, ptl_rd_q}) >= tsk_q.minl) &&
             (tsk_q.maxl[3] || ($signed({1'b0, ptl_rd_q}) <= tsk_q.maxl)));
    ddx    = 18'(ptx_rd_q) - 18'(tsk_q.px);
    ddy    = 18'(pty_rd_q) - 18'(tsk_q.py);
    adx    = ddx[17] ? 18'(-ddx) : 18'(ddx);
    ady    = ddy[17] ? 18'(-ddy) : 18'(ddy);
    box_ok = (adx < {2'b00, tsk_q.radius}) && (ady < {2'b00, tsk_q.radius});
    match  = lvl_ok && box_ok;
  end

  // control
  always_comb begin
    state_d    = state_q;
    ix_d       = ix_q;
    iy_d       = iy_q;
    j_d        = j_q;
    np_d       = np_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    pop_o      = 1'b0;
    fill_we    = 1'b0;
    fill_re    = 1'b0;
    fill_waddr = cell_addr;
    fill_wdata = '0;
    memb_we    = 1'b0;
    memb_re    = 1'b0;
    pt_we      = 1'b0;
    pt_re      = 1'b0;
    out_load   = 1'b0;
    out_d      = '0;
    out_d.last = 1'b1;
    case (state_q)
      S_INIT, S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        np_d       = '0;
        if (clr_q == CA_W'(NCELLS - 1)) state_d = (state_q == S_INIT) ? S_IDLE : S_CREPLY;
      end
      S_CREPLY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = REQ_CLEAR;
          state_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (task_valid_i) begin
          pop_o    = 1'b1;
          ix_d     = task_i.x0;
          iy_d     = task_i.y0;
          n_d      = '0;
          pend_v_d = 1'b0;
          case (task_i.kind)
            REQ_CLEAR:  state_d = S_CLR;
            REQ_INSERT: state_d = S_INS_RD;
            REQ_QUERY:  state_d = task_i.hit ? S_QCELL : S_QEND;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        fill_re = 1'b1;
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = REQ_INSERT;
          state_d    = S_IDLE;
          if (np_q >= NPW'(MAX_POINTS)) begin
            out_d.ovf = 1'b1;
          end else begin
            pt_we       = 1'b1;
            np_d        = np_q + NPW'(1);
            out_d.index = 11'(np_q);
            if (tsk_q.hit) begin
              if (fill_rd_q >= FW'(CELL_CAPACITY)) begin
                out_d.ovf = 1'b1;
              end else begin
                memb_we     = 1'b1;
                fill_we     = 1'b1;
                fill_wdata  = fill_rd_q + FW'(1);
                out_d.found = 1'b1;
              end
            end
          end
        end
      end
      S_QCELL: begin
        fill_re = 1'b1;
        state_d = S_QFILL;
      end
      S_QFILL: begin
        j_d = '0;
        if (fill_rd_q != '0)  state_d = S_QMRD;
        else if (last_cell)   state_d = S_QEND;
        else                  state_d = S_QCELL;
        if (fill_rd_q == '0 && !last_cell) begin
          if (iy_q == tsk_q.y1) begin
            iy_d = tsk_q.y0;
            ix_d = ix_q + CRD_W'(1);
          end else begin
            iy_d = iy_q + CRD_W'(1);
          end
        end
      end
      S_QMRD: begin
        memb_re = 1'b1;
        state_d = S_QMEM;
      end
      S_QMEM: begin
        pt_re   = 1'b1;
        state_d = S_QTEST;
      end
      S_QTEST: begin
        logic advance;
        advance = 1'b0;
        if (!match) begin
          advance = 1'b1;
        end else if (!pend_v_q) begin
          pend_v_d = 1'b1;
          pend_d   = memb_rd_q;
          n_d      = RW'(1);
          advance  = 1'b1;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = REQ_QUERY;
          out_d.index = 11'(pend_q);
          out_d.found = 1'b1;
          if (n_q == RW'(MAX_RESULTS)) begin
            out_d.ovf = 1'b1;
            state_d   = S_IDLE;
          end else begin
            out_d.last = 1'b0;
            pend_d     = memb_rd_q;
            n_d        = n_q + RW'(1);
            advance    = 1'b1;
          end
        end
        if (advance) begin
          if (FW'(j_q) + FW'(1) < fill_rd_q) begin
            j_d     = j_q + JW'(1);
            state_d = S_QMRD;
          end else if (last_cell) begin
            state_d = S_QEND;
          end else begin
            state_d = S_QCELL;
            if (iy_q == tsk_q.y1) begin
              iy_d = tsk_q.y0;
              ix_d = ix_q + CRD_W'(1);
            end else begin
              iy_d = iy_q + CRD_W'(1);
            end
          end
        end
      end
      S_QEND: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = REQ_QUERY;
          out_d.index = pend_v_q ? 11'(pend_q) : '0;
          out_d.found = pend_v_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      clr_q    <= '0;
      np_q     <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      np_q     <= np_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      if (fill_we && (state_q == S_INIT || state_q == S_CLR)) clr_q <= clr_q + CA_W'(1);
      else                                                   clr_q <= '0;
      if (out_load)         out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ix_q   <= ix_d;
    iy_q   <= iy_d;
    j_q    <= j_d;
    pend_q <= pend_d;
    if (pop_o)    tsk_q <= task_i;
    if (out_load) out_q <= out_d;
  end

  // cell fill memory
  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rd_q <= fill_mem[cell_addr];
  end

  // cell member memory
  always_ff @(posedge clk_i) begin
    if (memb_we) memb_mem[memb_waddr] <= IW'(np_q);
    if (memb_re) memb_rd_q <= memb_mem[memb_raddr];
  end

  // point stores
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      ptx_mem[IW'(np_q)] <= tsk_q.px;
      pty_mem[IW'(np_q)] <= tsk_q.py;
      ptl_mem[IW'(np_q)] <= tsk_q.level;
    end
    if (pt_re) begin
      ptx_rd_q <= ptx_mem[memb_rd_q];
      pty_rd_q <= pty_mem[memb_rd_q];
      ptl_rd_q <= ptl_mem[memb_rd_q];
    end
  end

  // the index counter never passes the store size
  a_np_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    np_q <= NPW'(MAX_POINTS))
    else $error("point counter beyond store size");

  // no request is taken during the clearing sweep
  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT || state_q == S_CLR) |-> !pop_o)
    else $error("request taken while clearing");

  // a reply never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("reply register overwritten");

  // a cell count written by an insert stays within capacity
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_we && state_q == S_INS_WR) |-> (fill_wdata <= FW'(CELL_CAPACITY)))
    else $error("cell count beyond capacity");

  // a truncated query reply closes the request
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.kind == REQ_QUERY && out_d.ovf) |-> out_d.last)
    else $error("truncation flag on an inner reply");

endmodule

/* src/keypoint_grid_area_query.sv */
// The front maps each request's positions to cells in steps on one shared multiplier.
// Insert: the back reads the cell count, then writes; clear: all counts are zeroed.
// Query: each covered cell's count is read, then each member and its point, through
// the one read port of the cell and point memories; the front works on the next
// request meanwhile. Reset: control registers clear at once, then the cell counts
// are swept to zero with s_axis_tready low.
`timescale 1ns / 1ps
module keypoint_grid_area_query import kgaq_pkg::*; #(
  parameter int GRID_COLS     = 64,
  parameter int GRID_ROWS     = 48,
  parameter int MAX_POINTS    = 2048,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_RESULTS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, level, radius, min_level, max_level, zero pad
  input  logic [63:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // index, found, overflow, zero pad
  output logic [15:0] m_axis_tdata,
  // reply_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  logic   back_ready, push, full, pop, tvalid;
  task_t  push_task, pop_task;
  reply_t reply;

  assign cfg_ready_o = 1'b1;

  kgaq_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .pos_x_i     ($signed(s_axis_tdata[16:0])),
    .pos_y_i     ($signed(s_axis_tdata[33:17])),
    .level_i     (s_axis_tdata[36:34]),
    .radius_i    (s_axis_tdata[52:37]),
    .min_level_i ($signed(s_axis_tdata[56:53])),
    .max_level_i ($signed(s_axis_tdata[60:57])),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .en_i        (back_ready),
    .full_i      (full),
    .push_o      (push),
    .task_o      (push_task)
  );

  kgaq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_task),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (tvalid),
    .data_o  (pop_task)
  );

  kgaq_back #(
    .GRID_COLS     (GRID_COLS),
    .GRID_ROWS     (GRID_ROWS),
    .MAX_POINTS    (MAX_POINTS),
    .CELL_CAPACITY (CELL_CAPACITY),
    .MAX_RESULTS   (MAX_RESULTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_valid_i (tvalid),
    .task_i       (pop_task),
    .pop_o        (pop),
    .ready_o      (back_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (reply)
  );

  // reply packing
  assign m_axis_tdata = {3'b000, reply.ovf, reply.found, reply.index};
  assign m_axis_tuser = reply.kind;
  assign m_axis_tlast = reply.last;

endmodule
